>>> hdl/rgbm_pkg.sv
// Package with types and constants of the running Gaussian background model.
package rgbm_pkg;

   typedef enum logic [1:0] {
      KIND_LOAD     = 2'd0,
      KIND_SUBTRACT = 2'd1,
      KIND_UPDATE   = 2'd2,
      KIND_NONE     = 2'd3
   } kind_type;

   localparam logic [2:0] CSR_ALPHA    = 3'd0;
   localparam logic [2:0] CSR_LOW      = 3'd1;
   localparam logic [2:0] CSR_HIGH     = 3'd2;
   localparam logic [2:0] CSR_LEARNING = 3'd3;
   localparam logic [2:0] CSR_INITVAR  = 3'd4;

   localparam logic [15:0] MEAN_MAX  = 16'hFF00;
   localparam logic [19:0] VAR_FLOOR = 20'd1024;

   typedef struct packed {
      logic [15:0] r;
      logic [15:0] g;
      logic [15:0] b;
   } mean_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic        upd;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
   } item_type;

   // Rounded alpha * d >> 16, half away from zero, d a signed Q8.8 value.
   function automatic logic signed [17:0] mean_step(input logic [15:0] alpha,
                                                    input logic signed [16:0] d);
      logic [15:0] mag;
      logic [32:0] prod;
      logic [16:0] r;
      mag  = d[16] ? 16'(-d) : 16'(d);
      prod = 33'(mag) * 33'(alpha) + 33'h8000;
      r    = prod[32:16];
      return d[16] ? -$signed({1'b0, r}) : $signed({1'b0, r});
   endfunction

endpackage

>>> hdl/running_gaussian_background_model_unit.sv
// Top level of the running Gaussian background model with per-pixel model memory.
// The unit accepts one item per clock and returns one result per item. The model
// memory is read at the edge that accepts an item; the distance and the new mean are
// formed in the next cycle, then the variance update, the threshold compares and the
// write back, and the result goes into the output register. A result
// that waits on rsp_tready holds the pipeline and the input until it is taken.
// Items that reach the same pixel while an earlier one is still in flight read
// forwarded model data, so back-to-back items to one pixel are fine. The model
// memory holds PIXELS entries; after reset a clearing pass writes zeros to every
// entry, one a cycle, and no item is accepted while it runs.
module running_gaussian_background_model_unit
   import rgbm_pkg::*;
#(
   parameter int PIXELS = 524288
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // kind, pixel_index, red, green, blue, mask_background, frame_number, zero pad
   input  logic [63:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // low_foreground, high_foreground, background_valid, red, green, blue, zero pad
   output logic [31:0] rsp_tdata,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   localparam int AW = (PIXELS > 1) ? $clog2(PIXELS) : 1;

   logic [15:0] alpha_ff, low_ff, high_ff, learn_ff;
   logic [7:0]  ivar_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_ff <= 16'd328;
         low_ff   <= 16'd512;
         high_ff  <= 16'd1024;
         learn_ff <= 16'd30;
         ivar_ff  <= 8'd36;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_ALPHA:    alpha_ff <= csr_wdata;
            CSR_LOW:      low_ff   <= csr_wdata;
            CSR_HIGH:     high_ff  <= csr_wdata;
            CSR_LEARNING: learn_ff <= csr_wdata;
            CSR_INITVAR:  ivar_ff  <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   logic [1:0]  in_kind;
   logic [18:0] in_pix;
   logic [7:0]  in_r, in_g, in_b;
   logic        in_mask;
   logic [15:0] in_frame;
   assign in_kind  = req_tdata[1:0];
   assign in_pix   = req_tdata[20:2];
   assign in_r     = req_tdata[28:21];
   assign in_g     = req_tdata[36:29];
   assign in_b     = req_tdata[44:37];
   assign in_mask  = req_tdata[45];
   assign in_frame = req_tdata[61:46];

   // Clearing pass.
   logic          clr_ff, clr_in;
   logic [AW:0]   clr_cnt_ff, clr_cnt_in;
   always_comb begin
      clr_in     = clr_ff;
      clr_cnt_in = clr_cnt_ff;
      if (clr_ff) begin
         clr_cnt_in = clr_cnt_ff + 1'b1;
         if (clr_cnt_ff == (AW+1)'(PIXELS - 1)) clr_in = 1'b0;
      end
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff     <= 1'b1;
         clr_cnt_ff <= '0;
      end else begin
         clr_ff     <= clr_in;
         clr_cnt_ff <= clr_cnt_in;
      end
   end

   // Output register and pipeline flow; stages advance together.
   logic v1_ff, v2_ff, v3_ff;
   logic advance;
   assign advance    = !v3_ff || rsp_tready;
   assign req_tready = advance && !clr_ff;
   logic acc;
   assign acc = req_tvalid && req_tready;

   // Stage 1: memory read.
   mean_type       mean_mem [PIXELS];
   logic [19:0]    var_mem  [PIXELS];
   mean_type       rd_mean_ff;
   logic [19:0]    rd_var_ff;
   logic [AW-1:0]  a1_ff;
   logic           ok1_ff;
   item_type       it1_ff;

   logic           we;
   logic [AW-1:0]  wa;
   mean_type       wmean;
   logic [19:0]    wvar;

   logic           in_ok;
   assign in_ok = ({13'd0, in_pix} < 32'(PIXELS)) && (in_kind != KIND_NONE);

   always_ff @(posedge clock) begin
      if (we) begin
         mean_mem[wa] <= wmean;
         var_mem[wa]  <= wvar;
      end
      if (acc) begin
         rd_mean_ff <= mean_mem[AW'(in_pix)];
         rd_var_ff  <= var_mem[AW'(in_pix)];
         a1_ff      <= AW'(in_pix);
         ok1_ff     <= in_ok;
         it1_ff     <= '{kind: in_kind,
                         upd: in_mask || (in_frame < learn_ff),
                         red: in_r, green: in_g, blue: in_b};
      end
   end

   // Stage 2 registers and stage 3 write-back registers, for forwarding.
   logic           ok2_ff;
   item_type       it2_ff;
   logic [AW-1:0]  a2_ff;
   logic [19:0]    var2_ff;
   logic [33:0]    dist_ff;
   logic [35:0]    lowp, highp;
   logic           wr2_ff;
   mean_type       nm2_ff;

   logic           wr3_ff;
   logic [AW-1:0]  a3_ff;
   mean_type       wm3_ff;
   logic [19:0]    wv3_ff;

   // Stage 2 computes final variance; its write reaches stage 1 by forwarding.
   logic           wr2_live;
   logic [19:0]    nv2;

   mean_type       m1;
   logic [19:0]    v1;
   always_comb begin
      m1 = rd_mean_ff;
      v1 = rd_var_ff;
      if (wr3_ff && a3_ff == a1_ff) begin
         m1 = wm3_ff;
         v1 = wv3_ff;
      end
      if (v2_ff && wr2_live && a2_ff == a1_ff) begin
         m1 = nm2_ff;
         v1 = nv2;
      end
   end

   logic signed [16:0] d_r, d_g, d_b;
   assign d_r = $signed({1'b0, m1.r}) - $signed({1'b0, it1_ff.red, 8'd0});
   assign d_g = $signed({1'b0, m1.g}) - $signed({1'b0, it1_ff.green, 8'd0});
   assign d_b = $signed({1'b0, m1.b}) - $signed({1'b0, it1_ff.blue, 8'd0});

   function automatic logic [15:0] sat_mean(input logic [15:0] m,
                                            input logic signed [17:0] s);
      logic signed [18:0] t;
      t = $signed({3'd0, m}) - 19'(s);
      if (t < 0) return 16'd0;
      if (t > $signed({3'd0, MEAN_MAX})) return MEAN_MAX;
      return t[15:0];
   endfunction

   logic     wr1;
   mean_type ld_mean, up_mean;
   assign wr1 = v1_ff && ok1_ff && (it1_ff.kind == KIND_LOAD ||
                (it1_ff.kind == KIND_UPDATE && it1_ff.upd));
   assign ld_mean = '{r: {it1_ff.red, 8'd0}, g: {it1_ff.green, 8'd0},
                      b: {it1_ff.blue, 8'd0}};
   assign up_mean = '{r: sat_mean(m1.r, mean_step(alpha_ff, d_r)),
                      g: sat_mean(m1.g, mean_step(alpha_ff, d_g)),
                      b: sat_mean(m1.b, mean_step(alpha_ff, d_b))};

   always_ff @(posedge clock) begin
      if (advance) begin
         ok2_ff   <= ok1_ff;
         it2_ff   <= it1_ff;
         a2_ff    <= a1_ff;
         var2_ff  <= v1;
         dist_ff  <= 34'(d_r * d_r) + 34'(d_g * d_g) + 34'(d_b * d_b);
         wr2_ff   <= wr1;
         nm2_ff   <= (it1_ff.kind == KIND_LOAD) ? ld_mean : up_mean;
      end
   end

   // Stage 2: threshold products and variance update.
   assign lowp  = 36'(low_ff) * 36'(var2_ff);
   assign highp = 36'(high_ff) * 36'(var2_ff);

   logic signed [35:0] vdiff;
   logic [35:0]        vmag;
   logic [51:0]        vprod;
   logic [27:0]        vr;
   logic signed [29:0] vnew;
   logic [19:0]        vcap;
   assign vdiff = $signed({2'b0, dist_ff}) - $signed({8'd0, var2_ff, 8'd0});
   assign vmag  = vdiff[35] ? 36'(-vdiff) : 36'(vdiff);
   assign vprod = 52'(vmag) * 52'(alpha_ff) + 52'h80_0000;
   assign vr    = vprod[51:24];
   assign vnew  = $signed({10'd0, var2_ff}) +
                  (vdiff[35] ? -$signed({2'b0, vr}) : $signed({2'b0, vr}));
   assign vcap  = {20'(ivar_ff) * 20'd5} << 8;
   always_comb begin
      if (it2_ff.kind == KIND_LOAD) nv2 = {4'd0, ivar_ff, 8'd0};
      else if (vnew < $signed({10'd0, VAR_FLOOR})) nv2 = VAR_FLOOR;
      else if (vnew > $signed({10'd0, vcap})) nv2 = vcap;
      else nv2 = vnew[19:0];
   end
   assign wr2_live = wr2_ff;

   logic clr_we;
   assign clr_we = clr_ff;
   assign we    = clr_we || (v2_ff && advance && wr2_ff);
   assign wa    = clr_we ? clr_cnt_ff[AW-1:0] : a2_ff;
   assign wmean = clr_we ? '0 : nm2_ff;
   assign wvar  = clr_we ? '0 : nv2;

   logic lo, hi, bv;
   assign lo = ok2_ff && it2_ff.kind == KIND_SUBTRACT && ({2'b0, dist_ff} > lowp);
   assign hi = ok2_ff && it2_ff.kind == KIND_SUBTRACT && ({2'b0, dist_ff} > highp);
   assign bv = ok2_ff && it2_ff.kind == KIND_UPDATE && wr2_ff;

   logic [7:0] br, bg, bb;
   assign br = bv ? 8'((17'(nm2_ff.r) + 17'd128) >> 8) : 8'd0;
   assign bg = bv ? 8'((17'(nm2_ff.g) + 17'd128) >> 8) : 8'd0;
   assign bb = bv ? 8'((17'(nm2_ff.b) + 17'd128) >> 8) : 8'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff  <= 1'b0;
         v2_ff  <= 1'b0;
         v3_ff  <= 1'b0;
         wr3_ff <= 1'b0;
      end else begin
         if (advance) begin
            v1_ff <= acc;
            v2_ff <= v1_ff;
            v3_ff <= v2_ff;
         end
         if (advance) wr3_ff <= v2_ff && wr2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         a3_ff     <= a2_ff;
         wm3_ff    <= nm2_ff;
         wv3_ff    <= nv2;
         rsp_tdata <= {5'd0, bb, bg, br, bv, hi, lo};
      end
   end
   assign rsp_tvalid = v3_ff;

`ifndef SYNTHESIS
   a_no_accept_clear: assert property (@(posedge clock) disable iff (reset)
      clr_ff |-> !req_tready) else $error("item accepted during clearing");
   a_hold_stall: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed under stall");
   a_fg_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[2] && (rsp_tdata[0] || rsp_tdata[1])))
      else $error("foreground and background flags together");
   a_no_write_stall: assert property (@(posedge clock) disable iff (reset)
      (we && !clr_ff) |-> advance) else $error("model written while stalled");
`endif

endmodule

>>> dv/tb_running_gaussian_background_model_unit.sv
// Self-checking testbench for the running Gaussian background model unit.
module tb_running_gaussian_background_model_unit;
   import rgbm_pkg::*;

   localparam int NPIX      = 524288;
   localparam int LIMIT     = 4000000;
   localparam int POOL      = 32;
   localparam int PHASES    = 6;
   localparam int PER_PHASE = 175;

   class pixel_model_scoreboard;
      logic [15:0] alpha, low_f, high_f, learn;
      logic [7:0]  init_var;
      logic [15:0] mean_mem[int][3];
      logic [19:0] var_mem[int];
      logic [31:0] pending[$];
      int          mismatches;
      int          results;

      function new();
         alpha = 328; low_f = 512; high_f = 1024; learn = 30; init_var = 36;
         mismatches = 0;
         results = 0;
      endfunction

      function void set_reg(logic [2:0] idx, logic [15:0] val);
         case (idx)
            CSR_ALPHA:    alpha = val;
            CSR_LOW:      low_f = val;
            CSR_HIGH:     high_f = val;
            CSR_LEARNING: learn = val;
            CSR_INITVAR:  init_var = val[7:0];
            default: ;
         endcase
      endfunction

      function longint rshift_round(longint v, int s);
         longint m;
         m = v < 0 ? -v : v;
         m = (m + (longint'(1) << (s - 1))) >>> s;
         return v < 0 ? -m : m;
      endfunction

      function void note_item(logic [63:0] data);
         kind_type    kind;
         int          pix;
         logic [7:0]  col[3];
         logic        bg;
         logic [15:0] frame;
         logic [31:0] res;
         longint      d[3];
         longint      dist_sq, v, m, nv, cap;
         logic [15:0] mn[3];
         kind  = kind_type'(data[1:0]);
         pix   = data[20:2];
         col[0] = data[28:21];
         col[1] = data[36:29];
         col[2] = data[44:37];
         bg    = data[45];
         frame = data[61:46];
         res   = '0;
         dist_sq = 0;
         for (int c = 0; c < 3; c++)
            mn[c] = mean_mem.exists(pix) ? mean_mem[pix][c] : 16'd0;
         v = var_mem.exists(pix) ? longint'(var_mem[pix]) : longint'(0);
         for (int c = 0; c < 3; c++) begin
            d[c] = longint'(mn[c]) - (longint'(col[c]) << 8);
            dist_sq += d[c] * d[c];
         end
         case (kind)
            KIND_LOAD: begin
               for (int c = 0; c < 3; c++)
                  mean_mem[pix][c] = {col[c], 8'd0};
               var_mem[pix] = {4'd0, init_var, 8'd0};
            end
            KIND_SUBTRACT: begin
               res[0] = dist_sq > longint'(low_f) * v;
               res[1] = dist_sq > longint'(high_f) * v;
            end
            KIND_UPDATE: begin
               if (bg || frame < learn) begin
                  for (int c = 0; c < 3; c++) begin
                     m = longint'(mn[c]) - rshift_round(longint'(alpha) * d[c], 16);
                     if (m < 0) m = 0;
                     if (m > longint'(MEAN_MAX)) m = MEAN_MAX;
                     mean_mem[pix][c] = m[15:0];
                  end
                  nv  = v + rshift_round(longint'(alpha) * (dist_sq - (v << 8)), 24);
                  cap = (5 * longint'(init_var)) << 8;
                  if (nv < longint'(VAR_FLOOR)) nv = VAR_FLOOR;
                  else if (nv > cap) nv = cap;
                  var_mem[pix] = nv[19:0];
                  res[2] = 1'b1;
                  for (int c = 0; c < 3; c++)
                     res[3 + 8 * c +: 8] = 8'((17'(mean_mem[pix][c]) + 17'd128) >> 8);
               end
            end
            default: ;
         endcase
         pending.push_back(res);
      endfunction

      function void check(logic [31:0] got);
         logic [31:0] exp;
         results++;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result item %h", got);
            return;
         end
         exp = pending.pop_front();
         if (got[0] !== exp[0] || got[1] !== exp[1] || got[2] !== exp[2] ||
             got[10:3] !== exp[10:3] || got[18:11] !== exp[18:11] ||
             got[26:19] !== exp[26:19] || got[31:27] !== exp[31:27]) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch lo/hi/bv %b%b%b rgb %0d %0d %0d, got %b%b%b rgb %0d %0d %0d",
                        exp[0], exp[1], exp[2], exp[10:3], exp[18:11], exp[26:19],
                        got[0], got[1], got[2], got[10:3], got[18:11], got[26:19]);
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [63:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;
   logic        csr_we;
   logic [2:0]  csr_index;
   logic [15:0] csr_wdata;

   pixel_model_scoreboard board = new();
   int          cycles = 0;
   int          stall_left = 0;
   bit          busy_sides = 1;
   int          pool_pix[POOL];
   logic [7:0]  pool_col[POOL][3];

   running_gaussian_background_model_unit DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            board.check(rsp_tdata);
            stall_left = busy_sides ? $urandom_range(0, 19) : 0;
         end
         if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   function automatic logic [63:0] pack_item(kind_type kind, int pix, logic [7:0] r,
                                             logic [7:0] g, logic [7:0] b, logic bg,
                                             logic [15:0] frame);
      return {2'b00, frame, bg, b, g, r, pix[18:0], kind};
   endfunction

   task automatic send(logic [63:0] data);
      int gap;
      gap = busy_sides ? $urandom_range(0, 19) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= data;
      do @(posedge clock); while (!req_tready);
      board.note_item(data);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_regs(logic [15:0] a, logic [15:0] lo, logic [15:0] hi,
                             logic [15:0] ln, logic [7:0] iv);
      logic [15:0] vals[5];
      vals = '{a, lo, hi, ln, {8'd0, iv}};
      for (int i = 0; i < 5; i++) begin
         csr_we    <= 1'b1;
         csr_index <= i[2:0];
         csr_wdata <= vals[i];
         @(posedge clock);
         board.set_reg(i[2:0], vals[i]);
      end
      csr_we <= 1'b0;
   endtask

   task automatic random_item();
      int          slot, sel, pix;
      kind_type    kind;
      logic [7:0]  c[3];
      logic [15:0] frame;
      slot = $urandom_range(0, POOL - 1);
      pix  = pool_pix[slot];
      sel  = $urandom_range(0, 99);
      if (sel < 10) kind = KIND_LOAD;
      else if (sel < 40) kind = KIND_SUBTRACT;
      else if (sel < 94) kind = KIND_UPDATE;
      else kind = KIND_NONE;
      if ($urandom_range(0, 19) == 0) pix = $urandom_range(0, NPIX - 1);
      for (int i = 0; i < 3; i++) begin
         if ($urandom_range(0, 2) == 0)
            c[i] = 8'($urandom_range(0, 255));
         else
            c[i] = pool_col[slot][i] + 8'($urandom_range(0, 12)) - 8'd6;
      end
      if (kind == KIND_LOAD)
         for (int i = 0; i < 3; i++) pool_col[slot][i] = c[i];
      frame = $urandom_range(0, 3) == 0 ? 16'($urandom_range(0, 65535))
                                        : 16'($urandom_range(0, 64));
      send(pack_item(kind, pix, c[0], c[1], c[2], 1'($urandom_range(0, 1)), frame));
   endtask

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      rsp_tready = 1'b0;
      csr_we     = 1'b0;
      csr_index  = '0;
      csr_wdata  = '0;
      pool_pix[0] = 0;
      pool_pix[1] = NPIX - 1;
      for (int i = 2; i < POOL; i++) pool_pix[i] = $urandom_range(0, NPIX - 1);
      for (int i = 0; i < POOL; i++)
         for (int c = 0; c < 3; c++) pool_col[i][c] = 8'($urandom_range(0, 255));
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      write_regs(16'd328, 16'd512, 16'd1024, 16'd30, 8'd36);

      send(pack_item(KIND_LOAD, 0, 8'd0, 8'd0, 8'd0, 1'b0, 16'd0));
      send(pack_item(KIND_LOAD, NPIX - 1, 8'd255, 8'd255, 8'd255, 1'b1, 16'hFFFF));
      send(pack_item(KIND_SUBTRACT, 0, 8'd255, 8'd255, 8'd255, 1'b0, 16'd0));
      send(pack_item(KIND_SUBTRACT, 0, 8'd0, 8'd0, 8'd0, 1'b1, 16'hFFFF));
      send(pack_item(KIND_UPDATE, 0, 8'd255, 8'd255, 8'd255, 1'b1, 16'hFFFF));
      send(pack_item(KIND_UPDATE, 0, 8'd255, 8'd0, 8'd128, 1'b0, 16'hFFFF));
      send(pack_item(KIND_UPDATE, 0, 8'd200, 8'd10, 8'd90, 1'b0, 16'd29));
      send(pack_item(KIND_UPDATE, 0, 8'd200, 8'd10, 8'd90, 1'b0, 16'd30));
      send(pack_item(KIND_UPDATE, NPIX - 1, 8'd0, 8'd0, 8'd0, 1'b1, 16'd0));
      send(pack_item(KIND_SUBTRACT, NPIX - 1, 8'd255, 8'd255, 8'd255, 1'b0, 16'd0));
      send(pack_item(KIND_SUBTRACT, 1234, 8'd0, 8'd0, 8'd0, 1'b0, 16'd0));
      send(pack_item(KIND_SUBTRACT, 1234, 8'd1, 8'd0, 8'd0, 1'b0, 16'd0));
      send(pack_item(KIND_UPDATE, 1234, 8'd77, 8'd88, 8'd99, 1'b1, 16'd5));
      send(pack_item(KIND_NONE, 0, 8'd255, 8'd255, 8'd255, 1'b1, 16'hFFFF));
      send(pack_item(KIND_SUBTRACT, 0, 8'd200, 8'd10, 8'd90, 1'b0, 16'd0));
      send(pack_item(KIND_UPDATE, 5, 8'd170, 8'd85, 8'd170, 1'b1, 16'hAAAA));
      send(pack_item(KIND_UPDATE, 6, 8'd85, 8'd170, 8'd85, 1'b0, 16'h5555));
      drain();

      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0: write_regs(16'd328, 16'd512, 16'd1024, 16'd30, 8'd36);
            1: write_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'd255);
            2: write_regs(16'd0, 16'd0, 16'd0, 16'd0, 8'd4);
            default: write_regs(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 4096)),
                                16'($urandom_range(0, 65535)), 16'($urandom_range(0, 40)),
                                8'($urandom_range(4, 255)));
         endcase
         busy_sides = (p != 3);
         for (int n = 0; n < PER_PHASE; n++) begin
            if (p == 4 && n == PER_PHASE / 2) begin
               req_tvalid <= 1'b0;
               while (board.pending.size() != 0) @(posedge clock);
               @(posedge clock);
            end
            random_item();
         end
         drain();
      end

      busy_sides = 1;
      $display("Checked %0d result items over %0d register settings,", board.results,
               PHASES + 1);
      $display("with load, subtract, update and ignored items under random stalls.");
      if (board.mismatches == 0 && board.pending.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("%0d mismatches, %0d results missing", board.mismatches,
                  board.pending.size());
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
